/* hdl/rgbseq_pkg.sv */
`timescale 1ns / 1ps

package rgbseq_pkg;

  localparam int LED_COUNT_DEFAULT = 16;
  localparam int BITS_PER_LED      = 24;

  localparam int WIDTH_W = 12;
  localparam int SLOTS_W = 8;
  localparam int INDEX_W = 10;
  localparam int BIT_W   = 5;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ZERO_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ONE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd2;

  localparam logic [WIDTH_W-1:0] ZERO_WIDTH_RESET  = 12'd42;
  localparam logic [WIDTH_W-1:0] ONE_WIDTH_RESET   = 12'd96;
  localparam logic [SLOTS_W-1:0] RESET_SLOTS_RESET = 8'd80;

  localparam logic [BIT_W-1:0] TOP_BIT = 5'(BITS_PER_LED - 1);

  typedef logic [BITS_PER_LED-1:0] colour_word_t;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] led_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } cmd_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] pulse_width;
    logic               output_enable;
    logic               frame_end;
  } result_t;

endpackage

/* hdl/rgb_led_pulse_width_sequencer_top.sv */
`timescale 1ns / 1ps
// A write item is taken while idle and gives no result; writes can follow back to back.
// A tick item reads the colour memory through its registered read port, and its result
// strobe is registered as the block leaves EMIT; busy is high for one cycle, in EMIT, and no
// new item is taken while it is high. The receiver cannot stall results. After reset a clearing
// pass zeroes all LED_COUNT colour memory words, one LED word per cycle, with busy held high.

module rgb_led_pulse_width_sequencer_top
  import rgbseq_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output result_t            result,
  output logic               result_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [WIDTH_W-1:0] cfg_data
);

  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state;

  logic [WIDTH_W-1:0] zero_width;
  logic [WIDTH_W-1:0] one_width;
  logic [SLOTS_W-1:0] reset_slots;

  // Slot position, kept as LED number, bit number and reset-slot count.
  logic               in_reset;
  logic [LED_W-1:0]   led_cnt;
  logic [BIT_W-1:0]   bit_cnt;
  logic [SLOTS_W-1:0] rcnt;

  // Slot being played by the tick in flight.
  logic               cur_reset;
  logic [LED_W-1:0]   cur_led;
  logic [BIT_W-1:0]   cur_bit;
  logic [SLOTS_W-1:0] cur_rcnt;

  logic [LED_W-1:0] clr_addr;

  logic         accept;
  logic         wrap;
  logic         wr_hit;
  logic         ram_we;
  logic [LED_W-1:0] ram_waddr;
  colour_word_t ram_wdata;
  logic [LED_W-1:0] eff_led;
  colour_word_t ram_rdata;
  logic         colour_last;
  logic         reset_last;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // A slot that lies past the frame end, after reset_slots was lowered, plays slot 0.
  assign wrap    = in_reset && (rcnt >= reset_slots);
  assign eff_led = wrap ? '0 : led_cnt;

  assign wr_hit = accept && (cmd.command == CMD_WRITE)
                  && ({1'b0, cmd.led_index} < (INDEX_W + 1)'(LED_COUNT));

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_hit;
      ram_waddr = cmd.led_index[LED_W-1:0];
      ram_wdata = {cmd.green, cmd.red, cmd.blue};
    end
  end

  rgbseq_ram #(
    .DEPTH  (LED_COUNT),
    .ADDR_W (LED_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (eff_led),
    .rdata (ram_rdata)
  );

  assign colour_last = (cur_led == LED_LAST) && (cur_bit == '0) && (reset_slots == '0);
  assign reset_last  = ({1'b0, cur_rcnt} + 9'd1) >= {1'b0, reset_slots};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      zero_width   <= ZERO_WIDTH_RESET;
      one_width    <= ONE_WIDTH_RESET;
      reset_slots  <= RESET_SLOTS_RESET;
      in_reset     <= 1'b0;
      led_cnt      <= '0;
      bit_cnt      <= TOP_BIT;
      rcnt         <= '0;
    end else begin
      result_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZERO_WIDTH:  zero_width  <= cfg_data;
          REG_ONE_WIDTH:   one_width   <= cfg_data;
          REG_RESET_SLOTS: reset_slots <= cfg_data[SLOTS_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_CLEAR: begin
          if (clr_addr == LED_LAST) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && (cmd.command == CMD_TICK)) begin
            cur_reset <= in_reset && !wrap;
            cur_led   <= eff_led;
            cur_bit   <= wrap ? TOP_BIT : bit_cnt;
            cur_rcnt  <= rcnt;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          state        <= ST_IDLE;
          if (!cur_reset) begin
            result.pulse_width   <= ram_rdata[cur_bit] ? one_width : zero_width;
            result.output_enable <= 1'b1;
            result.frame_end     <= colour_last;
            if (colour_last) begin
              in_reset <= 1'b0;
              led_cnt  <= '0;
              bit_cnt  <= TOP_BIT;
            end else if (cur_bit == '0) begin
              bit_cnt <= TOP_BIT;
              if (cur_led == LED_LAST) begin
                in_reset <= 1'b1;
                led_cnt  <= cur_led;
                rcnt     <= '0;
              end else begin
                in_reset <= 1'b0;
                led_cnt  <= cur_led + 1'b1;
              end
            end else begin
              in_reset <= 1'b0;
              led_cnt  <= cur_led;
              bit_cnt  <= cur_bit - 1'b1;
            end
          end else begin
            result.pulse_width   <= '0;
            result.output_enable <= 1'b0;
            result.frame_end     <= reset_last;
            if (reset_last) begin
              in_reset <= 1'b0;
              led_cnt  <= '0;
              bit_cnt  <= TOP_BIT;
            end else begin
              rcnt <= cur_rcnt + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.command == CMD_TICK) |=> ##1 result_valid)
    else $error("tick item did not produce a result");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.command == CMD_WRITE) |=> ##1 !result_valid)
    else $error("write item produced a result");

  a_off_means_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.output_enable |-> result.pulse_width == '0)
    else $error("reset slot carried a nonzero width");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    (bit_cnt <= TOP_BIT) && (led_cnt <= LED_LAST))
    else $error("slot counters out of range");

endmodule

/* hdl/rgbseq_ram.sv */
`timescale 1ns / 1ps

module rgbseq_ram
  import rgbseq_pkg::*;
#(
  parameter int DEPTH  = LED_COUNT_DEFAULT,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  colour_word_t      wdata,
  input  logic [ADDR_W-1:0] raddr,
  output colour_word_t      rdata
);

  colour_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sim/rgb_led_pulse_width_sequencer_top_tb.sv */
`timescale 1ns / 1ps

module rgb_led_pulse_width_sequencer_top_tb;
  import rgbseq_pkg::*;

  localparam int LEDS         = 16;
  localparam int COLOUR_SLOTS = LEDS * BITS_PER_LED;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  cmd_t               cmd;
  result_t            result;
  logic               result_valid;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [WIDTH_W-1:0] cfg_data;

  rgb_led_pulse_width_sequencer_top #(
    .LED_COUNT(LEDS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .result      (result),
    .result_valid(result_valid),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Shadow of the block's state, advanced as each item is taken.
  colour_word_t       colour_mem [LEDS];
  int unsigned        slot_pos;
  logic [WIDTH_W-1:0] zero_width;
  logic [WIDTH_W-1:0] one_width;
  logic [SLOTS_W-1:0] reset_slot_count;
  int unsigned        frames_played;

  result_t            pending_pulses [$];
  result_t            expected_pulse;
  int                 mismatch_count;
  bit                 steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic result_t next_pulse();
    int unsigned total;
    int unsigned pos;
    logic        code_bit;
    result_t     pulse;
    total = COLOUR_SLOTS + reset_slot_count;
    pos   = slot_pos;
    // A shortened frame can leave the position beyond its end; play slot 0 then.
    if (pos >= total) begin
      pos = 0;
    end
    if (pos < COLOUR_SLOTS) begin
      code_bit = colour_mem[pos / BITS_PER_LED][BITS_PER_LED - 1 - (pos % BITS_PER_LED)];
      pulse.pulse_width   = code_bit ? one_width : zero_width;
      pulse.output_enable = 1'b1;
    end else begin
      pulse.pulse_width   = '0;
      pulse.output_enable = 1'b0;
    end
    pulse.frame_end = (pos + 1 >= total);
    slot_pos = pulse.frame_end ? 0 : pos + 1;
    if (pulse.frame_end) begin
      frames_played++;
    end
    return pulse;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_pulses.size() == 0) begin
        $error("pulse with none expected: pulse_width %0d output_enable %0b frame_end %0b",
               result.pulse_width, result.output_enable, result.frame_end);
        mismatch_count++;
      end else begin
        expected_pulse = pending_pulses.pop_front();
        if (result.pulse_width !== expected_pulse.pulse_width) begin
          $error("pulse_width: expected %0d, actual %0d",
                 expected_pulse.pulse_width, result.pulse_width);
          mismatch_count++;
        end
        if (result.output_enable !== expected_pulse.output_enable) begin
          $error("output_enable: expected %0b, actual %0b",
                 expected_pulse.output_enable, result.output_enable);
          mismatch_count++;
        end
        if (result.frame_end !== expected_pulse.frame_end) begin
          $error("frame_end: expected %0b, actual %0b",
                 expected_pulse.frame_end, result.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int unsigned roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return 8'h00;
    end else if (roll == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  function automatic cmd_t random_item();
    cmd_t item;
    item.command   = ($urandom_range(0, 4) == 0) ? CMD_WRITE : CMD_TICK;
    item.led_index = ($urandom_range(0, 6) == 0) ? INDEX_W'($urandom)
                                                 : INDEX_W'($urandom_range(0, LEDS - 1));
    item.red       = pick_byte();
    item.green     = pick_byte();
    item.blue      = pick_byte();
    return item;
  endfunction

  function automatic cmd_t make_item(logic command, int unsigned index,
                                     logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    cmd_t item;
    item.command   = command;
    item.led_index = INDEX_W'(index);
    item.red       = red;
    item.green     = green;
    item.blue      = blue;
    return item;
  endfunction

  task automatic send_item(input cmd_t item, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= item;
    do @(posedge clk); while (busy);
    if (item.command == CMD_TICK) begin
      pending_pulses.push_back(next_pulse());
    end else if (item.led_index < LEDS) begin
      colour_mem[item.led_index] = {item.green, item.red, item.blue};
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [WIDTH_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_ZERO_WIDTH:  zero_width = data;
      REG_ONE_WIDTH:   one_width = data;
      REG_RESET_SLOTS: reset_slot_count = data[SLOTS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [WIDTH_W-1:0] zero_w, input logic [WIDTH_W-1:0] one_w,
                            input logic [WIDTH_W-1:0] slots);
    wait_idle();
    cfg_write(REG_ZERO_WIDTH, zero_w);
    cfg_write(REG_ONE_WIDTH, one_w);
    cfg_write(REG_RESET_SLOTS, slots);
  endtask

  task automatic test_directed_writes();
    int i;
    steady = 1'b1;
    // The first tick after reset must play a zero code from the cleared store.
    send_item(make_item(CMD_TICK, 0, 8'h00, 8'h00, 8'h00), 0);
    send_item(make_item(CMD_WRITE, 0, 8'h5A, 8'hFF, 8'h01), 0);
    send_item(make_item(CMD_WRITE, LEDS - 1, 8'hFF, 8'hFF, 8'hFF), 0);
    // Writes at or beyond the LED count must leave the store alone.
    send_item(make_item(CMD_WRITE, LEDS, 8'hFF, 8'hFF, 8'hFF), 0);
    send_item(make_item(CMD_WRITE, 1023, 8'hFF, 8'hFF, 8'hFF), 0);
    send_item(make_item(CMD_WRITE, 512, 8'hAA, 8'h55, 8'hC3), 0);
    send_item(make_item(CMD_WRITE, 1, 8'h00, 8'h80, 8'h00), 0);
    for (i = 0; i < 16; i++) begin
      send_item(make_item(CMD_TICK, $urandom, 8'($urandom), 8'($urandom), 8'($urandom)),
                (i < 8) ? 0 : $urandom_range(0, 3));
    end
  endtask

  task automatic test_random_frames(input bit write_cfg, input logic [WIDTH_W-1:0] zero_w,
                                    input logic [WIDTH_W-1:0] one_w,
                                    input logic [WIDTH_W-1:0] slots, input int count,
                                    input bit need_wrap);
    int          i;
    int unsigned frames_at_start;
    if (write_cfg) begin
      set_timing(zero_w, one_w, slots);
    end
    frames_at_start = frames_played;
    steady = 1'b0;
    // When asked, keep going until at least one frame has wrapped under this setting.
    for (i = 0; i < count || (need_wrap && frames_played == frames_at_start); i++) begin
      if (i % 50 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      send_item(random_item(), pick_gap());
    end
  endtask

  task automatic test_slot_past_end();
    int i;
    set_timing(12'($urandom), 12'($urandom), 12'd255);
    steady = 1'b0;
    while (slot_pos != COLOUR_SLOTS + 200) begin
      send_item(make_item(CMD_TICK, $urandom, 8'($urandom), 8'($urandom), 8'($urandom)),
                pick_gap());
    end
    // Shrinking the frame here leaves the position past its new end.
    wait_idle();
    cfg_write(REG_RESET_SLOTS, 12'd20);
    for (i = 0; i < 40; i++) begin
      send_item(random_item(), pick_gap());
    end
  endtask

  initial begin
    int i;
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_ZERO_WIDTH;
    cfg_data       = '0;
    mismatch_count = 0;
    steady         = 1'b0;
    for (i = 0; i < LEDS; i++) begin
      colour_mem[i] = '0;
    end
    slot_pos         = 0;
    frames_played    = 0;
    zero_width       = ZERO_WIDTH_RESET;
    one_width        = ONE_WIDTH_RESET;
    reset_slot_count = RESET_SLOTS_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_writes();
    test_random_frames(1'b0, '0, '0, '0, 150, 1'b0);
    test_random_frames(1'b1, 12'd0, 12'd0, 12'd0, 150, 1'b1);
    test_random_frames(1'b1, 12'd4095, 12'd4095, 12'd255, 150, 1'b0);
    test_random_frames(1'b1, 12'd1, 12'd4095, 12'd1, 150, 1'b1);
    test_random_frames(1'b1, 12'($urandom), 12'($urandom), 12'($urandom), 150, 1'b0);
    test_slot_past_end();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_pulses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
